### hdl/masked_byte_pattern_search_assert.svh
// Assertion macros used by the masked byte pattern search RTL.
`ifndef MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH

// Same-cycle implication, sampled on clk and ignored while arst_n is low.
`define MBPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, sampled on clk and ignored while arst_n is low.
`define MBPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

### hdl/mbps_pkg.sv
// Types and constants of the masked byte pattern search.
`timescale 1ns / 1ps

package mbps_pkg;

	localparam int PAT_BYTES = 24;
	localparam int PAT_WORDS = 3;
	localparam int ADDR_W    = 64;
	localparam int CFG_W     = 64;
	localparam int CARE_W    = 24;
	localparam int LEN_REG_W = 5;
	localparam int CFG_IDX_W = 3;

	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [CFG_W-1:0]     cfg_data_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW  = 3'd0,
		REG_PAT_MID  = 3'd1,
		REG_PAT_HIGH = 3'd2,
		REG_CARE     = 3'd3,
		REG_LENGTH   = 3'd4,
		REG_BASE     = 3'd5
	} cfg_reg_t;

endpackage

### hdl/mbps_byte_if.sv
// Channel that carries the region bytes into the search.
`timescale 1ns / 1ps

interface mbps_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### hdl/mbps_result_if.sv
// Channel that carries one search result per region.
`timescale 1ns / 1ps

interface mbps_result_if;
	logic                  valid;
	logic                  ready;
	logic                  found;
	logic [mbps_pkg::ADDR_W-1:0] match_address;

	modport source (output valid, output found, output match_address, input ready);
	modport sink   (input valid, input found, input match_address, output ready);
endinterface

### hdl/masked_byte_pattern_search.sv
// Top level of the masked byte pattern search with its configuration registers.
//
//   channel      direction  payload
//   data_chan    sink       data_byte[7:0], last_byte
//   result_chan  source     found, match_address[63:0]
//   cfg_*        write      cfg_index[2:0], cfg_data[63:0] on cfg_write
//
// One byte is taken every cycle while data_chan.ready is high; any result is registered.
// The window compare, offset subtract and base add sit between the window and result registers.
// A full result register that is not taken holds data_chan.ready low until it drains.
// arst_n clears the window, position, region flag and result valid, and returns the
// configuration registers to their reset values.
`timescale 1ns / 1ps

`include "masked_byte_pattern_search_assert.svh"

module masked_byte_pattern_search #(
	parameter int MAX_PATTERN   = 24,
	parameter int POSITION_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	mbps_byte_if.sink               data_chan,
	mbps_result_if.source           result_chan,
	input  logic                    cfg_write,
	input  mbps_pkg::cfg_idx_t      cfg_index,
	input  mbps_pkg::cfg_data_t     cfg_data
);
	import mbps_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	logic [PAT_WORDS-1:0][CFG_W-1:0] pattern_q;
	logic [CARE_W-1:0]               care_q;
	logic [LEN_REG_W-1:0]            length_q;
	addr_t                           base_q;

	logic [MAX_PATTERN-1:0][7:0]     window_q;
	logic [MAX_PATTERN-1:0][7:0]     window_next;
	logic [POSITION_BITS-1:0]        pos_q;
	logic [POSITION_BITS-1:0]        pos_next;
	logic [POSITION_BITS-1:0]        offset;
	logic                            reported_q;

	logic                            out_valid_q;
	logic                            found_q;
	addr_t                           address_q;

	logic [LEN_W-1:0]                len_eff;
	logic                            all_match;
	logic                            hit;
	logic                            accept;
	logic                            emit;

	always_comb begin
		if (length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (32'(length_q) > MAX_PATTERN) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = LEN_W'(length_q);
		end
	end

	always_comb begin
		window_next[0] = data_chan.data_byte;
		for (int j = 1; j < MAX_PATTERN; j++) begin
			window_next[j] = window_q[j-1];
		end
	end

	assign pos_next = (pos_q == '1) ? pos_q : pos_q + POSITION_BITS'(1);
	assign offset   = pos_next - POSITION_BITS'(len_eff);

	mbps_match #(
		.MAX_PATTERN (MAX_PATTERN),
		.LEN_W       (LEN_W)
	) u_match (
		.window    (window_next),
		.pattern   (pattern_q),
		.care      (care_q),
		.len       (len_eff),
		.all_match (all_match)
	);

	assign hit    = all_match && !reported_q && (pos_next >= POSITION_BITS'(len_eff));
	assign accept = data_chan.valid && data_chan.ready;
	assign emit   = accept && (hit || (data_chan.last_byte && !reported_q));

	assign data_chan.ready = !out_valid_q || result_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			care_q    <= '1;
			length_q  <= LEN_REG_W'(1);
			base_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PAT_LOW:  pattern_q[0] <= cfg_data;
				REG_PAT_MID:  pattern_q[1] <= cfg_data;
				REG_PAT_HIGH: pattern_q[2] <= cfg_data;
				REG_CARE:     care_q       <= cfg_data[CARE_W-1:0];
				REG_LENGTH:   length_q     <= cfg_data[LEN_REG_W-1:0];
				REG_BASE:     base_q       <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			pos_q      <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (data_chan.last_byte) begin
				window_q   <= '0;
				pos_q      <= '0;
				reported_q <= 1'b0;
			end else begin
				window_q   <= window_next;
				pos_q      <= pos_next;
				reported_q <= reported_q || hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_q   <= hit;
			address_q <= hit ? base_q + ADDR_W'(offset) : '0;
		end
	end

	assign result_chan.valid         = out_valid_q;
	assign result_chan.found         = found_q;
	assign result_chan.match_address = address_q;

	`MBPS_ASSERT_NOW(a_stall_blocks_input, out_valid_q && !result_chan.ready, !data_chan.ready)
	`MBPS_ASSERT_NOW(a_miss_has_zero_addr, out_valid_q && !found_q, address_q == '0)
	`MBPS_ASSERT_NEXT(a_region_end_clears, accept && data_chan.last_byte, pos_q == '0 && !reported_q)
	`MBPS_ASSERT_NOW(a_report_needs_bytes, reported_q, pos_q != '0)

endmodule

### hdl/mbps_match.sv
// Parallel masked compare of the byte window against the pattern.
`timescale 1ns / 1ps

module mbps_match #(
	parameter int MAX_PATTERN = 24,
	parameter int LEN_W       = 5
) (
	input  logic [MAX_PATTERN-1:0][7:0]           window,
	input  logic [mbps_pkg::PAT_BYTES-1:0][7:0]   pattern,
	input  logic [mbps_pkg::CARE_W-1:0]           care,
	input  logic [LEN_W-1:0]                      len,
	output logic                                  all_match
);
	import mbps_pkg::*;

	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [MAX_PATTERN-1:0] byte_ok;

	// Pattern byte k lines up with the window byte len-1-k (newest byte at 0).
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cmp
		logic [LEN_W-1:0] idx;
		logic             in_use;

		assign in_use = LEN_W'(k) < len;
		assign idx    = len - LEN_W'(k + 1);

		if (k < PAT_BYTES) begin : g_reg
			assign byte_ok[k] = !in_use || !care[k] || (pattern[k] == window[idx[IDX_W-1:0]]);
		end else begin : g_wild
			assign byte_ok[k] = 1'b1;
		end
	end

	assign all_match = &byte_ok;

endmodule
